>>> rtl/rlc_pkg.sv
`default_nettype none

package rlc_pkg;

    localparam int unsigned LANES_DEFAULT = 8;
    localparam int unsigned LANES_MAX     = 32;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LANE_W   = 4;
    localparam int unsigned LOCK_W   = 16;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = LOCK_W;

    // s_axis tdata: lane[3:0], pin_low[4], now_ms[36:5], zero pad to 40
    localparam int unsigned S_TDATA_W = 40;
    // m_axis tdata: lane_out[3:0], lap_ms[35:4], zero pad to 40
    localparam int unsigned M_TDATA_W = 40;

    localparam logic [LOCK_W-1:0] STARTER_LOCKOUT_RST = 16'd1000;
    localparam logic [LOCK_W-1:0] LANE_LOCKOUT_RST    = 16'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STARTER_LOCKOUT = 1'b0,
        REG_LANE_LOCKOUT    = 1'b1
    } rlc_reg_t;

    // Input command and output event kind share the same encoding
    typedef enum logic {
        KIND_START = 1'b0,
        KIND_LAP   = 1'b1
    } rlc_kind_t;

    typedef struct packed {
        logic start_hit;
        logic lap_hit;
    } rlc_hit_t;

endpackage

`default_nettype wire

>>> rtl/rlc_eval.sv
`default_nettype none

module rlc_eval #(
    parameter int unsigned LANES = rlc_pkg::LANES_DEFAULT,
    parameter int unsigned IDX_W = 3
) (
    input  wire logic                          cmd,
    input  wire logic [rlc_pkg::LANE_W-1:0]    lane,
    input  wire logic                          pin_low,
    input  wire logic [rlc_pkg::TIME_W-1:0]    now_ms,
    input  wire logic                          running,
    input  wire logic [rlc_pkg::TIME_W-1:0]    start_time,
    input  wire logic [rlc_pkg::TIME_W-1:0]    last_start,
    input  wire logic [rlc_pkg::TIME_W-1:0]    last_touch [LANES],
    input  wire logic [rlc_pkg::LOCK_W-1:0]    starter_lockout,
    input  wire logic [rlc_pkg::LOCK_W-1:0]    lane_lockout,
    output rlc_pkg::rlc_hit_t                  hit,
    output logic      [IDX_W-1:0]              lane_idx,
    output logic      [rlc_pkg::TIME_W-1:0]    elapsed
);

    logic [rlc_pkg::LANE_W-1:0] lane_m1;
    logic                       lane_ok;
    logic [rlc_pkg::TIME_W-1:0] start_gap;
    logic [rlc_pkg::TIME_W-1:0] touch_gap;

    assign lane_m1  = lane - rlc_pkg::LANE_W'(1);
    assign lane_idx = IDX_W'(lane_m1);
    assign lane_ok  = (lane != '0) && (32'(lane) <= 32'(LANES));

    // Gaps wrap modulo 2^32; lockout must be strictly exceeded
    assign start_gap = now_ms - last_start;
    assign touch_gap = lane_ok ? (now_ms - last_touch[lane_idx]) : '0;
    assign elapsed   = now_ms - start_time;

    always_comb begin
        hit.start_hit = (cmd == rlc_pkg::KIND_START) && !running && pin_low
                        && (start_gap > rlc_pkg::TIME_W'(starter_lockout));
        hit.lap_hit   = (cmd == rlc_pkg::KIND_LAP) && running && pin_low && lane_ok
                        && (touch_gap > rlc_pkg::TIME_W'(lane_lockout));
    end

endmodule

`default_nettype wire

>>> rtl/race_lap_capture_with_lockout.sv
`default_nettype none

// Race timer front end. Each transaction on s_axis is one falling edge from the
// starter (tuser 0) or from a lane touch pad (tuser 1) with its millisecond
// timestamp. A valid start moves the block to running and yields a start event;
// a valid touch while running yields the lane and the time since the start.
// Rejected edges (pin not low, lockout not passed, wrong state, lane out of
// range) produce no output. The block takes one transaction per cycle while
// s_axis_tready is high; an accepted input waits in the input register until the
// result register is free, then its result is loaded there and shown on m_axis. A
// stalled result holds the input register, and a second waiting input then
// drops s_axis_tready. Only reset returns the race to ready. The user must write
// lockout registers through cfg_* only while idle; the block itself does not enforce it.
module race_lap_capture_with_lockout #(
    parameter int unsigned LANES = rlc_pkg::LANES_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [rlc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rlc_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // lane[3:0], pin_low[4], now_ms[36:5], zero[39:37]
    input  wire logic [rlc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // command[0]
    input  wire logic                              s_axis_tuser,

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // lane_out[3:0], lap_ms[35:4], zero[39:36]
    output logic      [rlc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // event_kind[0]
    output logic                                   m_axis_tuser
);

    localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int unsigned T_W   = rlc_pkg::TIME_W;
    localparam int unsigned L_W   = rlc_pkg::LANE_W;

    logic [rlc_pkg::LOCK_W-1:0] starter_lockout_reg;
    logic [rlc_pkg::LOCK_W-1:0] lane_lockout_reg;

    logic             in_valid_reg;
    logic             in_cmd_reg;
    logic [L_W-1:0]   in_lane_reg;
    logic             in_pin_reg;
    logic [T_W-1:0]   in_now_reg;

    logic             running_reg;
    logic [T_W-1:0]   start_time_reg;
    logic [T_W-1:0]   last_start_reg;
    logic [T_W-1:0]   last_touch_reg [LANES];

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [L_W-1:0]   out_lane_reg;
    logic [T_W-1:0]   out_elapsed_reg;

    rlc_pkg::rlc_hit_t hit;
    logic [IDX_W-1:0]  lane_idx;
    logic [T_W-1:0]    elapsed;

    logic out_free;
    logic advance;
    logic s_take;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    rlc_eval #(
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_eval (
        .cmd             (in_cmd_reg),
        .lane            (in_lane_reg),
        .pin_low         (in_pin_reg),
        .now_ms          (in_now_reg),
        .running         (running_reg),
        .start_time      (start_time_reg),
        .last_start      (last_start_reg),
        .last_touch      (last_touch_reg),
        .starter_lockout (starter_lockout_reg),
        .lane_lockout    (lane_lockout_reg),
        .hit             (hit),
        .lane_idx        (lane_idx),
        .elapsed         (elapsed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            starter_lockout_reg <= rlc_pkg::STARTER_LOCKOUT_RST;
            lane_lockout_reg    <= rlc_pkg::LANE_LOCKOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rlc_pkg::REG_STARTER_LOCKOUT: starter_lockout_reg <= cfg_wdata;
                rlc_pkg::REG_LANE_LOCKOUT:    lane_lockout_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_cmd_reg  <= s_axis_tuser;
            in_lane_reg <= s_axis_tdata[L_W-1:0];
            in_pin_reg  <= s_axis_tdata[L_W];
            in_now_reg  <= s_axis_tdata[L_W+T_W:L_W+1];
        end
    end

    // Race state: commit only when the item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= 1'b0;
            start_time_reg <= '0;
            last_start_reg <= '0;
            for (int i = 0; i < LANES; i++) begin
                last_touch_reg[i] <= '0;
            end
        end else if (advance) begin
            if (hit.start_hit) begin
                running_reg    <= 1'b1;
                start_time_reg <= in_now_reg;
                last_start_reg <= in_now_reg;
            end
            if (hit.lap_hit) begin
                last_touch_reg[lane_idx] <= in_now_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && (hit.start_hit || hit.lap_hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (hit.start_hit || hit.lap_hit)) begin
            if (hit.lap_hit) begin
                out_kind_reg    <= rlc_pkg::KIND_LAP;
                out_lane_reg    <= in_lane_reg;
                out_elapsed_reg <= elapsed;
            end else begin
                out_kind_reg    <= rlc_pkg::KIND_START;
                out_lane_reg    <= '0;
                out_elapsed_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {(rlc_pkg::M_TDATA_W - L_W - T_W)'(0), out_elapsed_reg, out_lane_reg};

endmodule

`default_nettype wire

>>> rtl/rlc_checker.sv
`default_nettype none

module rlc_checker #(
    parameter int unsigned LANES = rlc_pkg::LANES_DEFAULT
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [rlc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("m_axis result changed while stalled");

    // A start event carries no lane and no elapsed time
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == rlc_pkg::KIND_START) |-> (m_axis_tdata == '0))
        else $error("start event with nonzero payload");

    // A lap event names a lane in range
    a_lap_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == rlc_pkg::KIND_LAP) |->
            (m_axis_tdata[rlc_pkg::LANE_W-1:0] != '0)
            && (32'(m_axis_tdata[rlc_pkg::LANE_W-1:0]) <= 32'(LANES)))
        else $error("lap event with lane out of range");

    // Drop any result on reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

endmodule

bind race_lap_capture_with_lockout rlc_checker #(
    .LANES (LANES)
) u_rlc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
